FILE: hdl/eight_way_sorted_list_merge_assert.svh
// Assertion macros shared by the merge block's modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef EIGHT_WAY_SORTED_LIST_MERGE_ASSERT_SVH
`define EIGHT_WAY_SORTED_LIST_MERGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EWSLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EWSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ewslm_pkg.sv
// Shared types and codes for the eight-way sorted list merge.
// No dependencies; imported by the controller, datapath and top level.
package ewslm_pkg;

    localparam int NUM_LISTS = 8;
    localparam int IDX_W     = 3;
    localparam int IN_W      = 32;
    localparam int RES_W     = 32;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TAKE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic tree1;
        logic tree2;
        logic do_exec;
        logic do_pick;
        logic do_fill;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_take;
        logic refetch;
    } stat_t;

endpackage

FILE: hdl/eight_way_sorted_list_merge.sv
// Top level of the eight-way sorted list merge: controller plus datapath.
// Depends on ewslm_pkg, ewslm_ctrl and ewslm_dpath.

// Eight lists of LIST_DEPTH signed words each share one memory with one write and one
// registered read port. Every list's current head is cached in a register, so a take
// compares eight registers through a three-level minimum tree, the first two levels
// registered and the final pick combinational, and advances the winner (lowest list
// index on equal heads). Words are handled one at a time. A load, clear or unused opcode
// is executed in the EXEC state, which writes its result once the output register is
// free, and the block then returns to idle. A take steps through EXEC and MIN2 to PICK,
// which writes its result once the output register is free, then passes through FILL
// when the advanced list still holds unread entries, as the next head is then read from
// the memory port into its cache register. The result sits in an output register, so
// the next word is accepted while it waits; that word then holds in its last stage until
// the pending result is taken. Memory contents need no reset: fill counts gate every
// read, so no clearing pass runs after reset.
module eight_way_sorted_list_merge
    import ewslm_pkg::*;
#(
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic [IDX_W-1:0]        list_index,
    input  logic signed [IN_W-1:0]  value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [RES_W-1:0] value_res,
    output logic [1:0]              status
);

    cmd_t  cmd;
    stat_t stat;

    ewslm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ewslm_dpath #(
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .opcode     (opcode),
        .list_index (list_index),
        .value      (value),
        .value_res  (value_res),
        .status     (status)
    );

endmodule

FILE: hdl/ewslm_ctrl.sv
// Sequencing state machine for the merge block: handshakes and command strobes.
// Depends on ewslm_pkg and the assertion macro header.
`include "eight_way_sorted_list_merge_assert.svh"

module ewslm_ctrl
    import ewslm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MIN2 = 5'b00100,
        S_PICK = 5'b01000,
        S_FILL = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.tree1 = 1'b1;
                if (stat.is_take)
                begin
                    state_next = S_MIN2;
                end
                else if (out_free)
                begin
                    cmd.do_exec = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_MIN2:
            begin
                cmd.tree2  = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                // hold the winner until the output slot is free
                if (out_free)
                begin
                    cmd.do_pick = 1'b1;
                    state_next  = stat.refetch ? S_FILL : S_IDLE;
                end
            end
            S_FILL:
            begin
                cmd.do_fill = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.do_exec || cmd.do_pick)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `EWSLM_ASSERT_NOW(a_commit_slot_free, cmd.do_exec || cmd.do_pick, out_free, "result written over a pending word")
    `EWSLM_ASSERT_NEXT(a_commit_shows, cmd.do_exec || cmd.do_pick, out_valid_reg, "result not presented after commit")
    `EWSLM_ASSERT_NEXT(a_refetch_fill, cmd.do_pick && stat.refetch, state_reg == S_FILL, "head refill skipped")

endmodule

FILE: hdl/ewslm_dpath.sv
// Datapath of the merge block: list memory, fill and read counters, cached heads,
// registered minimum tree and result register. Depends on ewslm_pkg and the macro header.
`include "eight_way_sorted_list_merge_assert.svh"

module ewslm_dpath
    import ewslm_pkg::*;
#(
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic [1:0]              opcode,
    input  logic [IDX_W-1:0]        list_index,
    input  logic signed [IN_W-1:0]  value,
    output logic signed [RES_W-1:0] value_res,
    output logic [1:0]              status
);

    localparam int AW        = $clog2(LIST_DEPTH);
    localparam int CW        = $clog2(LIST_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LISTS << AW;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    logic [1:0]                    op_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic signed [VALUE_WIDTH-1:0] val_reg;

    logic [CW-1:0] fill_reg [NUM_LISTS];
    logic [CW-1:0] fill_next [NUM_LISTS];
    logic [CW-1:0] rd_reg [NUM_LISTS];
    logic [CW-1:0] rd_next [NUM_LISTS];

    logic signed [VALUE_WIDTH-1:0] head_reg [NUM_LISTS];
    logic [NUM_LISTS-1:0]          head_ok;

    logic [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rdata_reg;
    logic [IDX_W-1:0]              refill_idx_reg;

    logic signed [VALUE_WIDTH-1:0] l1_val_reg [4];
    logic [IDX_W-1:0]              l1_idx_reg [4];
    logic [3:0]                    l1_ok_reg;
    logic signed [VALUE_WIDTH-1:0] l2_val_reg [2];
    logic [IDX_W-1:0]              l2_idx_reg [2];
    logic [1:0]                    l2_ok_reg;

    logic signed [VALUE_WIDTH-1:0] win_val;
    logic [IDX_W-1:0]              win_idx;
    logic                          win_ok;
    logic                          pick_hi;
    logic [CW-1:0]                 rd_plus;
    logic                          refetch;

    logic                  sel_full;
    logic                  do_write;
    logic [IDX_W+AW-1:0]   waddr;
    logic [IDX_W+AW-1:0]   raddr;

    logic signed [RES_W-1:0] value_res_reg;
    logic [1:0]              status_reg;

    assign value_res    = value_res_reg;
    assign status       = status_reg;
    assign stat.is_take = (op_reg == OP_TAKE);
    assign stat.refetch = refetch;

    assign sel_full = (fill_reg[idx_reg] == DEPTH_C);
    assign do_write = cmd.do_exec && (op_reg == OP_LOAD) && !sel_full;
    assign waddr    = {idx_reg, fill_reg[idx_reg][AW-1:0]};

    // final stage of the tree: lower index wins on a tie
    assign pick_hi = l2_ok_reg[1] && (!l2_ok_reg[0] || (l2_val_reg[1] < l2_val_reg[0]));
    assign win_val = pick_hi ? l2_val_reg[1] : l2_val_reg[0];
    assign win_idx = pick_hi ? l2_idx_reg[1] : l2_idx_reg[0];
    assign win_ok  = l2_ok_reg[0] || l2_ok_reg[1];
    assign rd_plus = CW'(rd_reg[win_idx] + 1'b1);
    assign refetch = win_ok && (rd_plus < fill_reg[win_idx]);
    assign raddr   = {win_idx, rd_plus[AW-1:0]};

    always_comb
    begin
        for (int k = 0; k < NUM_LISTS; k++)
        begin
            head_ok[k] = (rd_reg[k] < fill_reg[k]);
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        rd_next   = rd_reg;
        if (cmd.do_exec && (op_reg == OP_CLEAR))
        begin
            for (int k = 0; k < NUM_LISTS; k++)
            begin
                fill_next[k] = '0;
                rd_next[k]   = '0;
            end
        end
        else if (do_write)
        begin
            fill_next[idx_reg] = CW'(fill_reg[idx_reg] + 1'b1);
        end
        if (cmd.do_pick && win_ok)
        begin
            rd_next[win_idx] = rd_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_LISTS; k++)
            begin
                fill_reg[k] <= '0;
                rd_reg[k]   <= '0;
            end
        end
        else
        begin
            fill_reg <= fill_next;
            rd_reg   <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            idx_reg <= list_index;
            val_reg <= VALUE_WIDTH'(value);
        end
    end

    // list memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[waddr] <= val_reg;
        end
        if (cmd.do_pick && refetch)
        begin
            rdata_reg <= mem[raddr];
        end
        if (cmd.do_pick)
        begin
            refill_idx_reg <= win_idx;
        end
    end

    // cached heads: a load into a drained list lands here directly
    always_ff @(posedge clk)
    begin
        if (do_write && (rd_reg[idx_reg] == fill_reg[idx_reg]))
        begin
            head_reg[idx_reg] <= val_reg;
        end
        if (cmd.do_fill)
        begin
            head_reg[refill_idx_reg] <= rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tree1)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (head_ok[2*j+1] && (!head_ok[2*j] || (head_reg[2*j+1] < head_reg[2*j])))
                begin
                    l1_val_reg[j] <= head_reg[2*j+1];
                    l1_idx_reg[j] <= IDX_W'(2*j+1);
                end
                else
                begin
                    l1_val_reg[j] <= head_reg[2*j];
                    l1_idx_reg[j] <= IDX_W'(2*j);
                end
                l1_ok_reg[j] <= head_ok[2*j] || head_ok[2*j+1];
            end
        end
        if (cmd.tree2)
        begin
            for (int j = 0; j < 2; j++)
            begin
                if (l1_ok_reg[2*j+1]
                    && (!l1_ok_reg[2*j] || (l1_val_reg[2*j+1] < l1_val_reg[2*j])))
                begin
                    l2_val_reg[j] <= l1_val_reg[2*j+1];
                    l2_idx_reg[j] <= l1_idx_reg[2*j+1];
                end
                else
                begin
                    l2_val_reg[j] <= l1_val_reg[2*j];
                    l2_idx_reg[j] <= l1_idx_reg[2*j];
                end
                l2_ok_reg[j] <= l1_ok_reg[2*j] || l1_ok_reg[2*j+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_exec)
        begin
            value_res_reg <= '0;
            status_reg    <= ((op_reg == OP_LOAD) && sel_full) ? ST_FULL : ST_DONE;
        end
        else if (cmd.do_pick)
        begin
            value_res_reg <= win_ok ? RES_W'(win_val) : '0;
            status_reg    <= win_ok ? ST_DONE : ST_EMPTY;
        end
    end

    for (genvar g = 0; g < NUM_LISTS; g++)
    begin : g_chk
        `EWSLM_ASSERT_NOW(a_rd_le_fill, 1'b1, rd_reg[g] <= fill_reg[g], "read position beyond fill")
        `EWSLM_ASSERT_NOW(a_fill_le_depth, 1'b1, fill_reg[g] <= DEPTH_C, "fill beyond list depth")
        `EWSLM_ASSERT_NEXT(a_clear_empties, cmd.do_exec && (op_reg == OP_CLEAR), fill_reg[g] == '0, "clear left entries")
    end

endmodule

FILE: verif/tb_top.sv
// Testbench for the eight-way sorted list merge: drives words with random gaps and stalls,
// predicts every result in a scoreboard class and checks it field by field.
// Depends on ewslm_pkg and the eight_way_sorted_list_merge top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ewslm_pkg::*;

    localparam int LIST_DEPTH    = 64;
    localparam int IDLE_LIMIT    = 400;
    localparam int TARGET_WORDS  = 1200;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_GAP       = 16;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic signed [RES_W-1:0] val;
        logic [1:0]              st;
    } merge_result_t;

    class merge_predictor;
        logic signed [IN_W-1:0] store [NUM_LISTS][LIST_DEPTH];
        int unsigned            fill [NUM_LISTS];
        int unsigned            rd_pos [NUM_LISTS];
        merge_result_t          pending[$];
        int                     errors;

        function new();
            for (int k = 0; k < NUM_LISTS; k++)
            begin
                fill[k]   = 0;
                rd_pos[k] = 0;
            end
            errors = 0;
        endfunction

        // Work out the result that an accepted word must give and queue it.
        function void note_word(logic [1:0] op, logic [IDX_W-1:0] idx,
                                logic signed [IN_W-1:0] val);
            merge_result_t          r;
            bit                     found;
            int                     best_k;
            logic signed [IN_W-1:0] best_v;
            logic signed [IN_W-1:0] h;
            r.val  = '0;
            r.st   = ST_DONE;
            found  = 0;
            best_k = 0;
            best_v = '0;
            case (op)
                OP_LOAD:
                begin
                    if (fill[idx] >= LIST_DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        store[idx][fill[idx]] = val;
                        fill[idx]++;
                    end
                end
                OP_TAKE:
                begin
                    // lowest index wins on equal heads
                    for (int k = 0; k < NUM_LISTS; k++)
                    begin
                        if (rd_pos[k] < fill[k] && rd_pos[k] < LIST_DEPTH)
                        begin
                            h = store[k][rd_pos[k]];
                            if (!found || h < best_v)
                            begin
                                found  = 1;
                                best_k = k;
                                best_v = h;
                            end
                        end
                    end
                    if (found)
                    begin
                        rd_pos[best_k]++;
                        r.val = best_v;
                    end
                    else
                        r.st = ST_EMPTY;
                end
                OP_CLEAR:
                begin
                    for (int k = 0; k < NUM_LISTS; k++)
                    begin
                        fill[k]   = 0;
                        rd_pos[k] = 0;
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_word(logic signed [RES_W-1:0] got_val, logic [1:0] got_st);
            merge_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result word: value_res %0d status %0d", got_val, got_st);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got_val !== exp_r.val)
            begin
                $error("value_res: expected %0d, got %0d", exp_r.val, got_val);
                errors++;
            end
            if (got_st !== exp_r.st)
            begin
                $error("status: expected %0d, got %0d", exp_r.st, got_st);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              opcode;
    logic [IDX_W-1:0]        list_index;
    logic signed [IN_W-1:0]  value;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [RES_W-1:0] value_res;
    logic [1:0]              status;

    merge_predictor sb;
    bit             no_idling;
    int             words_sent;
    int             idle_cycles;
    longint         tail [NUM_LISTS];
    bit             tail_set [NUM_LISTS];

    eight_way_sorted_list_merge #(
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (32)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .list_index (list_index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value_res  (value_res),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int draw_gap();
        return no_idling ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Next value for list k that keeps the list ascending; wide spreads over the full range.
    function automatic logic signed [IN_W-1:0] next_sorted(int k, bit wide);
        int     seed_v;
        longint t;
        if (!tail_set[k])
        begin
            seed_v      = $urandom;
            tail[k]     = wide ? longint'(seed_v) : longint'($urandom_range(0, 3)) - 2;
            tail_set[k] = 1;
        end
        else
        begin
            t = tail[k] + (wide ? longint'($urandom_range(0, 32'h0800_0000))
                                : longint'($urandom_range(0, 2)));
            tail[k] = (t > 64'sd2147483647) ? 64'sd2147483647 : t;
        end
        return tail[k][IN_W-1:0];
    endfunction

    task automatic send_word(logic [1:0] op, logic [IDX_W-1:0] idx, logic signed [IN_W-1:0] val);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        list_index <= idx;
        value      <= val;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(op, idx, val);
        words_sent++;
        if (op == OP_CLEAR)
        begin
            for (int k = 0; k < NUM_LISTS; k++)
                tail_set[k] = 0;
        end
    endtask

    task automatic send_load(int k, bit wide);
        send_word(OP_LOAD, k[IDX_W-1:0], next_sorted(k, wide));
    endtask

    // Drop valid and hold until every queued result has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random stall per word, then take it.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_word(value_res, status);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("tb_top: errors");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int  sel;
        int  n;
        int  k;
        int  scen;
        bit  wide;
        bit  do_clear;
        sb          = new();
        no_idling   = 0;
        words_sent  = 0;
        idle_cycles = 0;
        for (int j = 0; j < NUM_LISTS; j++)
            tail_set[j] = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_LOAD;
        list_index = '0;
        value      = '0;
        out_ready  = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty take, unused opcode, extremes, equal heads, reload, unsorted
        send_word(OP_TAKE, 3'd0, 32'sd0);
        send_word(OP_UNUSED, 3'd6, 32'sd77);
        send_word(OP_CLEAR, 3'd0, 32'sd0);
        send_word(OP_LOAD, 3'd0, 32'h8000_0000);
        send_word(OP_LOAD, 3'd7, 32'h7fff_ffff);
        send_word(OP_LOAD, 3'd3, 32'sd5);
        send_word(OP_LOAD, 3'd5, 32'sd5);
        send_word(OP_LOAD, 3'd1, -32'sd1);
        repeat (5) send_word(OP_TAKE, 3'd0, 32'sd0);
        send_word(OP_TAKE, 3'd2, 32'sd0);
        send_word(OP_LOAD, 3'd3, 32'sd1);
        send_word(OP_TAKE, 3'd0, 32'sd0);
        send_word(OP_LOAD, 3'd4, 32'sd10);
        send_word(OP_LOAD, 3'd4, 32'sd2);
        send_word(OP_LOAD, 3'd6, 32'sd4);
        repeat (3) send_word(OP_TAKE, 3'd0, 32'sd0);
        send_word(OP_CLEAR, 3'd0, 32'sd0);
        send_word(OP_TAKE, 3'd0, 32'sd0);
        wait_drained();

        scen = 0;
        while (words_sent < TARGET_WORDS)
        begin
            sel       = $urandom_range(0, 9);
            wide      = 1'($urandom_range(0, 1));
            no_idling = ($urandom_range(0, 3) == 0);
            if (sel <= 5)
            begin
                // sorted loads across random lists, then merge them out
                do_clear = ($urandom_range(0, 4) != 0);
                if (do_clear)
                    send_word(OP_CLEAR, IDX_W'($urandom_range(0, 7)), $urandom);
                n = $urandom_range(1, 40);
                repeat (n) send_load($urandom_range(0, 7), wide);
                repeat (n + $urandom_range(0, 2))
                    send_word(OP_TAKE, IDX_W'($urandom_range(0, 7)), $urandom);
            end
            else if (sel == 6)
            begin
                // overfill one list
                send_word(OP_CLEAR, IDX_W'($urandom_range(0, 7)), $urandom);
                k = $urandom_range(0, 7);
                repeat (LIST_DEPTH + $urandom_range(1, 4)) send_load(k, wide);
                repeat ($urandom_range(0, 5))
                    send_word(OP_TAKE, IDX_W'($urandom_range(0, 7)), $urandom);
            end
            else if (sel == 7)
            begin
                // loads interleaved with takes
                repeat (30)
                begin
                    if ($urandom_range(0, 2) == 0)
                        send_word(OP_TAKE, IDX_W'($urandom_range(0, 7)), $urandom);
                    else
                        send_load($urandom_range(0, 7), wide);
                end
            end
            else
            begin
                repeat (20)
                    send_word(2'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 7)),
                              $urandom);
            end
            if (scen == 0 || $urandom_range(0, 3) == 0)
                wait_drained();
            scen++;
        end

        no_idling = 0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
